// File: rtl/alt_pkg.sv
// Shared types and constants for the advisory lock table.
package alt_pkg;

    localparam int MODE_W        = 2;
    localparam int HOLDER_W      = 7;
    localparam int KEY_W         = 32;
    localparam int SLOT_OUT_W    = 5;

    // bit positions inside the mode field
    localparam int MODE_EXCL_BIT    = 0;
    localparam int MODE_RELEASE_BIT = 1;

    typedef enum logic [1:0] {
        ST_GRANTED  = 2'd0,
        ST_CONFLICT = 2'd1,
        ST_NO_SLOT  = 2'd2,
        ST_RELEASED = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MOD,
        S_SCAN,
        S_COMMIT
    } t_state;

    typedef struct packed {
        logic [MODE_W-1:0]   mode;
        logic [HOLDER_W-1:0] holder_id;
        logic [KEY_W-1:0]    lock_key;
    } t_req;

    typedef struct packed {
        t_status                 status;
        logic                    wake_waiters;
        logic [SLOT_OUT_W-1:0]   slot_used;
    } t_rsp;

    typedef struct packed {
        logic [HOLDER_W-1:0] holder;
        logic [KEY_W-1:0]    key;
        logic                excl;
    } t_entry;

endpackage

// File: rtl/alt_holder_mod.sv
// Holder id reduced modulo the holder count through a constant lookup table.
module alt_holder_mod #(
    parameter int HOLDER_COUNT = 128
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_load,
    input  logic [alt_pkg::HOLDER_W-1:0]   i_holder,
    output logic                           o_done,
    output logic [alt_pkg::HOLDER_W-1:0]   o_who
);
    import alt_pkg::*;

    localparam int HOLDER_VALUES = 2 ** HOLDER_W;
    localparam int MOD_TBL_W     = HOLDER_VALUES * HOLDER_W;

    // residue of every possible holder id, built at elaboration
    function automatic logic [MOD_TBL_W-1:0] build_mod_tbl();
        logic [MOD_TBL_W-1:0] tbl;
        tbl = '0;
        for (int i = 0; i < HOLDER_VALUES; i++) begin
            tbl[i*HOLDER_W +: HOLDER_W] = HOLDER_W'(i % HOLDER_COUNT);
        end
        return tbl;
    endfunction

    localparam logic [MOD_TBL_W-1:0] MOD_TBL = build_mod_tbl();

    logic [HOLDER_W-1:0] r_who;
    logic                r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_who <= MOD_TBL[i_holder*HOLDER_W +: HOLDER_W];
        end
    end

    assign o_done = r_done;
    assign o_who  = r_who;

endmodule

// File: rtl/alt_entry_mem.sv
// Entry store: holder, key and exclusive mark, one write and one registered read port.
module alt_entry_mem #(
    parameter int DEPTH = 32
) (
    input  logic                      i_clk,
    input  logic                      i_we,
    input  logic [$clog2(DEPTH)-1:0]  i_waddr,
    input  alt_pkg::t_entry           i_wdata,
    input  logic [$clog2(DEPTH)-1:0]  i_raddr,
    output alt_pkg::t_entry           o_rdata
);
    import alt_pkg::*;

    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/advisory_lock_table.sv
// Advisory lock table top level: request sequencer, slot scan and commit.
//
//  channel   direction  handshake              payload
//  request   in         start, busy            i_req (t_req)
//  result    out        o_rsp_valid (strobe)   o_rsp (t_rsp)
//
// A request passes from accept to the result strobe through the holder reduction
// table lookup, the scan through the entry memory's single read port, and the
// commit.
// busy is high from accept until the result strobe; one request at a time.
// Synchronous active-low reset empties the table; no clearing pass is needed.
// The result is held for exactly one cycle; the receiver cannot stall it.
module advisory_lock_table #(
    parameter int LOCK_SLOTS   = 32,
    parameter int HOLDER_COUNT = 128
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  alt_pkg::t_req i_req,
    output logic          o_rsp_valid,
    output alt_pkg::t_rsp o_rsp
);
    import alt_pkg::*;

    localparam int IDX_W = $clog2(LOCK_SLOTS);
    localparam int CNT_W = $clog2(LOCK_SLOTS + 1);
    localparam logic [CNT_W-1:0] SCAN_END = CNT_W'(LOCK_SLOTS);

    t_state                r_state, n_state;
    t_req                  r_req, n_req;
    logic [HOLDER_W-1:0]   r_who, n_who;
    logic [CNT_W-1:0]      r_idx, n_idx;
    logic [IDX_W-1:0]      r_cmp_idx, n_cmp_idx;
    logic                  r_cmp_vld, n_cmp_vld;
    logic [LOCK_SLOTS-1:0] r_valid, n_valid;
    logic [LOCK_SLOTS-1:0] r_mark, n_mark;
    logic                  r_conflict, n_conflict;
    logic                  r_have_free, n_have_free;
    logic                  r_have_own, n_have_own;
    logic [IDX_W-1:0]      r_first_free, n_first_free;
    logic [IDX_W-1:0]      r_own, n_own;
    t_rsp                  r_rsp, n_rsp;
    logic                  r_rsp_valid, n_rsp_valid;

    logic                  mod_load;
    logic                  mod_done;
    logic [HOLDER_W-1:0]   mod_who;
    logic                  mem_we;
    logic [IDX_W-1:0]      wr_addr;
    t_entry                wr_entry;
    t_entry                rd_entry;
    logic [IDX_W+SLOT_OUT_W-1:0] slot_ext;

    alt_holder_mod #(
        .HOLDER_COUNT (HOLDER_COUNT)
    ) u_mod (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (mod_load),
        .i_holder (r_req.holder_id),
        .o_done   (mod_done),
        .o_who    (mod_who)
    );

    alt_entry_mem #(
        .DEPTH (LOCK_SLOTS)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (wr_addr),
        .i_wdata (wr_entry),
        .i_raddr (r_idx[IDX_W-1:0]),
        .o_rdata (rd_entry)
    );

    always_comb begin
        n_state      = r_state;
        n_req        = r_req;
        n_who        = r_who;
        n_idx        = r_idx;
        n_cmp_idx    = r_cmp_idx;
        n_cmp_vld    = r_cmp_vld;
        n_valid      = r_valid;
        n_mark       = r_mark;
        n_conflict   = r_conflict;
        n_have_free  = r_have_free;
        n_have_own   = r_have_own;
        n_first_free = r_first_free;
        n_own        = r_own;
        n_rsp        = r_rsp;
        n_rsp_valid  = 1'b0;
        mod_load     = 1'b0;
        mem_we       = 1'b0;
        wr_addr      = r_have_own ? r_own : r_first_free;
        wr_entry     = '{holder: r_who, key: r_req.lock_key,
                         excl: r_req.mode[MODE_EXCL_BIT]};
        slot_ext     = (IDX_W + SLOT_OUT_W)'(wr_addr);

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_req   = i_req;
                    n_state = S_MOD;
                end
            end
            S_MOD: begin
                // the reduction unit is loaded in the first cycle here
                mod_load = !mod_done && (r_idx != '1);
                if (mod_load) begin
                    n_idx = '1;
                end
                if (mod_done) begin
                    n_who        = mod_who;
                    n_idx        = '0;
                    n_cmp_vld    = 1'b0;
                    n_mark       = '0;
                    n_conflict   = 1'b0;
                    n_have_free  = 1'b0;
                    n_have_own   = 1'b0;
                    n_first_free = '0;
                    n_own        = '0;
                    n_state      = S_SCAN;
                end
            end
            S_SCAN: begin
                // the memory read is registered, so each compare uses the previous scan index
                if (r_cmp_vld) begin
                    if (!r_valid[r_cmp_idx]) begin
                        if (!r_have_free) begin
                            n_first_free = r_cmp_idx;
                            n_have_free  = 1'b1;
                        end
                    end else if (rd_entry.holder == r_who) begin
                        n_own             = r_cmp_idx;
                        n_have_own        = 1'b1;
                        n_mark[r_cmp_idx] = 1'b1;
                    end else if (rd_entry.key == r_req.lock_key &&
                                 (r_req.mode[MODE_EXCL_BIT] || rd_entry.excl)) begin
                        n_conflict = 1'b1;
                    end
                end
                n_cmp_idx = r_idx[IDX_W-1:0];
                n_cmp_vld = (r_idx != SCAN_END);
                if (r_idx != SCAN_END) begin
                    n_idx = r_idx + 1'b1;
                end else begin
                    n_state = S_COMMIT;
                end
            end
            S_COMMIT: begin
                n_rsp_valid = 1'b1;
                n_state     = S_IDLE;
                priority if (r_req.mode[MODE_RELEASE_BIT]) begin
                    n_valid = r_valid & ~r_mark;
                    n_rsp   = '{status: ST_RELEASED, wake_waiters: |r_mark,
                                slot_used: '0};
                end else if (r_conflict) begin
                    n_rsp   = '{status: ST_CONFLICT, wake_waiters: 1'b0,
                                slot_used: '0};
                end else if (!r_have_own && !r_have_free) begin
                    n_rsp   = '{status: ST_NO_SLOT, wake_waiters: 1'b0,
                                slot_used: '0};
                end else begin
                    // keep the holder's last entry, drop its duplicates
                    mem_we  = 1'b1;
                    n_valid = (r_valid & ~r_mark) | (LOCK_SLOTS'(1) << wr_addr);
                    n_rsp   = '{status: ST_GRANTED, wake_waiters: 1'b1,
                                slot_used: slot_ext[SLOT_OUT_W-1:0]};
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_valid     <= '0;
            r_rsp_valid <= 1'b0;
            r_cmp_vld   <= 1'b0;
            r_idx       <= '0;
        end else begin
            r_state     <= n_state;
            r_valid     <= n_valid;
            r_rsp_valid <= n_rsp_valid;
            r_cmp_vld   <= n_cmp_vld;
            r_idx       <= (r_state == S_IDLE) ? '0 : n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req        <= n_req;
        r_who        <= n_who;
        r_cmp_idx    <= n_cmp_idx;
        r_mark       <= n_mark;
        r_conflict   <= n_conflict;
        r_have_free  <= n_have_free;
        r_have_own   <= n_have_own;
        r_first_free <= n_first_free;
        r_own        <= n_own;
        r_rsp        <= n_rsp;
    end

    assign busy        = (r_state != S_IDLE);
    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

    a_rsp_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rsp_valid |=> !r_rsp_valid)
        else $error("result strobe longer than one cycle");

    a_commit_rsp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_COMMIT) |=> (r_rsp_valid && r_state == S_IDLE))
        else $error("commit did not produce a result");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not raise busy");

    a_refused_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rsp_valid && (r_rsp.status == ST_CONFLICT || r_rsp.status == ST_NO_SLOT))
        |-> (!r_rsp.wake_waiters && r_rsp.slot_used == '0))
        else $error("refused request reported wake or slot");

    a_grant_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_COMMIT && mem_we) |=> r_valid[$past(wr_addr)])
        else $error("granted slot not marked valid");

endmodule
